FILE: src/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg: shared types and constants of the label address table
// Opcodes, status codes, entry and command layouts, label normalization.
// ----------------------------------------------------------------------------
package lat_pkg;

	localparam int LABEL_BYTES = 9;
	localparam int LABEL_W     = 72;
	localparam int TOTAL_W     = 5;

	localparam logic [2:0] OP_INSERT    = 3'd0;
	localparam logic [2:0] OP_DELETE    = 3'd1;
	localparam logic [2:0] OP_SEARCH    = 3'd2;
	localparam logic [2:0] OP_RELABEL   = 3'd3;
	localparam logic [2:0] OP_READDRESS = 3'd4;
	localparam logic [2:0] OP_REWRITE   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DUPLICATE = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef logic [LABEL_W-1:0] label_t;

	typedef struct packed {
		label_t             label;
		logic signed [31:0] address;
	} entry_t;

	typedef struct packed {
		logic [2:0]         opcode;
		label_t             key;
		label_t             new_key;
		logic signed [31:0] address;
	} cmd_t;

	typedef struct packed {
		logic       done;
		logic [1:0] status;
		logic       found;
	} res_t;

	// Clear every byte from the first zero byte on, and bytes past LABEL_BYTES.
	function automatic label_t norm_label(logic [63:0] head, logic [7:0] tail);
		label_t     lbl;
		logic       ended;
		logic [7:0] b;
		lbl   = {head, tail};
		ended = 1'b0;
		for (int i = 0; i < 9; i++) begin
			b = lbl[LABEL_W-1-8*i -: 8];
			if (i >= LABEL_BYTES || ended) begin
				b = 8'd0;
			end
			if (b == 8'd0) begin
				ended = 1'b1;
			end
			lbl[LABEL_W-1-8*i -: 8] = b;
		end
		return lbl;
	endfunction

endpackage

FILE: src/lat_ram.sv
// ----------------------------------------------------------------------------
// lat_ram: entry storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lat_ram
	import lat_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/lat_seq.sv
// ----------------------------------------------------------------------------
// lat_seq: table sequencer
// Scans the packed entries for the oldest match, then inserts, rewrites or
// closes the gap left by a delete, one RAM access per port per cycle.
// ----------------------------------------------------------------------------
module lat_seq
	import lat_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  cmd_t          cmd,
	output logic          busy,
	output res_t          res,
	output logic [CW-1:0] count,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  entry_t        rd_data,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_ACT   = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] count_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          found_q;
	logic [1:0]    status_q;
	logic [AW-1:0] slot_q;
	entry_t        hit_q;
	logic          found_now;
	logic          room;
	logic          drained;

	assign room      = count_q < CW'(DEPTH);
	assign drained   = (ptr_q >= count_q) && !rd_vld_s1;
	assign found_now = (state_q == S_SCAN) && rd_vld_s1 && (rd_data.label == cmd.key);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = rd_data;
		case (state_q)
			S_SCAN: begin
				rd_en = (ptr_q < count_q) && !found_now;
			end
			S_ACT: begin
				case (cmd.opcode)
					OP_INSERT: begin
						wr_en   = !found_q && room;
						wr_addr = count_q[AW-1:0];
						wr_data = '{label: cmd.key, address: cmd.address};
					end
					OP_RELABEL, OP_READDRESS, OP_REWRITE: begin
						wr_en   = found_q;
						wr_addr = slot_q;
						wr_data.label   = (cmd.opcode != OP_READDRESS) ? cmd.new_key
							: hit_q.label;
						wr_data.address = (cmd.opcode != OP_RELABEL) ? cmd.address
							: hit_q.address;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			S_SHIFT: begin
				// read slot i+1 while slot i-1 takes the word read in the previous cycle
				rd_en   = ptr_q < count_q;
				wr_en   = rd_vld_s1;
				wr_addr = rd_idx_s1 - 1'b1;
				wr_data = rd_data;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ptr_q     <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			case (state_q)
				S_IDLE, S_DONE: begin
					if (go) begin
						state_q <= S_SCAN;
						ptr_q   <= '0;
						found_q <= 1'b0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (found_now) begin
						found_q <= 1'b1;
						state_q <= S_ACT;
					end else if (drained) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					status_q <= ST_OK;
					state_q  <= S_DONE;
					case (cmd.opcode)
						OP_INSERT: begin
							if (found_q) begin
								status_q <= ST_DUPLICATE;
							end else if (!room) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						OP_DELETE: begin
							if (!found_q) begin
								status_q <= ST_NOT_FOUND;
							end else begin
								ptr_q   <= CW'(slot_q) + 1'b1;
								state_q <= S_SHIFT;
							end
						end
						OP_SEARCH, OP_RELABEL, OP_READDRESS, OP_REWRITE: begin
							if (!found_q) begin
								status_q <= ST_NOT_FOUND;
							end
						end
						default: begin
							status_q <= ST_OK;
						end
					endcase
				end
				S_SHIFT: begin
					if (drained) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if (found_now) begin
			slot_q <= rd_idx_s1;
			hit_q  <= rd_data;
		end
	end

	assign busy       = !((state_q == S_IDLE) || (state_q == S_DONE));
	assign res.done   = state_q == S_DONE;
	assign res.status = status_q;
	assign res.found  = found_q;
	assign count      = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !res.done)
		else $error("done strobe held longer than one cycle");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_ACT) || (state_q == S_SHIFT))
		else $error("RAM write outside act or shift");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write hit the same entry");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ACT) && (cmd.opcode == OP_INSERT) && !found_q && room)
		|=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("insert did not grow the table");

endmodule

FILE: src/label_address_table_core.sv
// ----------------------------------------------------------------------------
// label_address_table_core: associative label to address table
// Top level: command capture with label normalization, entry RAM, sequencer.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low. It
// runs alone: the sequencer scans the entries held in slots 0..count-1 of a
// one-read one-write RAM with a registered read, one compare per cycle,
// stopping at the oldest match. A miss spends the scan reading every entry,
// comparing the last word read and then seeing the read pipe empty. Then
// come the act state and the done state. Delete then closes the gap, moving
// each later entry down one slot at one entry per cycle; when the deleted
// entry was the last, the shift state finds nothing to move.
// The result is valid on status, found and entry_total in the single cycle
// in which done is high; there is no back pressure, so the receiver must
// take it then. busy drops in that done cycle, so the next transaction may
// start at the same edge at which the result is taken.
// Labels are compared as strings: bytes after the first zero byte read as
// zero, for the key and for the replacement label alike. Relabel does not
// check for duplicates; later lookups act on the oldest matching entry.
// entry_total is the entry count after the transaction, reduced to 5 bits.
// ----------------------------------------------------------------------------
module label_address_table_core
	import lat_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          opcode,
	input  logic [63:0]         key_head,
	input  logic [7:0]          key_tail,
	input  logic [63:0]         new_key_head,
	input  logic [7:0]          new_key_tail,
	input  logic signed [31:0]  new_address,
	output logic                done,
	output logic [1:0]          status,
	output logic                found,
	output logic [TOTAL_W-1:0]  entry_total
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic          accept;
	cmd_t          cmd_q;
	res_t          res;
	logic [CW-1:0] count;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	assign accept = start && !busy;

	// Labels are normalized once at capture, so the scan compares raw words.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.opcode  <= opcode;
			cmd_q.key     <= norm_label(key_head, key_tail);
			cmd_q.new_key <= norm_label(new_key_head, new_key_tail);
			cmd_q.address <= new_address;
		end
	end

	lat_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lat_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept),
		.cmd     (cmd_q),
		.busy    (busy),
		.res     (res),
		.count   (count),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign done        = res.done;
	assign status      = res.status;
	assign found       = res.found;
	assign entry_total = TOTAL_W'(count);

endmodule
